// File: src/mclw_pkg.sv
// Package for the multi-channel liveness watchdog: request/response payload types,
// operation and status codes, register map and reset values. No dependencies.
`default_nettype none

package mclw_pkg;

   // Table size default, handed to the top level parameter.
   localparam int unsigned SLOTS_DEFAULT = 16;

   // Register reset values.
   localparam logic [31:0] GRACE_RESET = 32'd60000;
   localparam int unsigned TICK_W      = 10;
   localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1);

   // Limit arithmetic: period * 3, saturating.
   localparam logic [31:0] LIMIT_MAX  = 32'hFFFF_FFFF;
   localparam logic [31:0] PERIOD_SAT = LIMIT_MAX / 32'd3;

   // Operation codes.
   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_ALIVE    = 2'd1;
   localparam logic [1:0] OP_SCAN     = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_ARG = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // Register map: registers at byte address 4*i, read as 32-bit words.
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_SEL_BIT = 2;
   localparam logic        CSR_GRACE   = 1'b0;
   localparam logic        CSR_TICK    = 1'b1;

   localparam logic [7:0] NULL_ID = 8'd0;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  task_id;
      logic [31:0] task_period;
      logic [31:0] now_tick;
      logic        kernel_running;
      logic [7:0]  holder_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        escalate;
      logic        deferred;
      logic [3:0]  slot_index;
      logic [7:0]  stalled_id;
      logic [31:0] silence_span;
      logic [31:0] deadline_span;
      logic [31:0] stall_period;
      logic [31:0] deferral_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/mclw_req_if.sv
// Request channel of the liveness watchdog: valid/ready handshake and request payload.
// Depends on mclw_pkg.
`default_nettype none

interface mclw_req_if import mclw_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/mclw_rsp_if.sv
// Response channel of the liveness watchdog: valid/ready handshake and response payload.
// Depends on mclw_pkg.
`default_nettype none

interface mclw_rsp_if import mclw_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/multi_channel_liveness_watchdog.sv
// Top level of the multi-channel liveness watchdog: slot table in two memories,
// sweep controller and APB-style register port. Depends on mclw_pkg, mclw_req_if, mclw_rsp_if.
//
// Usage:
//  - req_chan carries one request: register a task, report it alive, or scan the table.
//    Each request yields exactly one response on rsp_chan.
//  - Register, alive and scan requests sweep the whole table, one slot per cycle through
//    the single read port of the slot memories. Requests refused for a bad argument skip
//    the sweep and go straight to the finish step.
//  - One request is in flight at a time: req_chan.ready is high only while the block is
//    idle, so a new request is taken only once the last answer has left the controller.
//  - The response sits in an output register. The next request is accepted while it
//    waits; that request's answer holds in the controller until the register is free,
//    so a stalled receiver stalls the block after one request.
//  - Reset (synchronous, active high) clears all slot flags, the deferral count and the
//    registers (grace 60000 ms, 1 ms per tick). Slot ids, periods and ticks are not
//    cleared; a slot is read only once its used flag is set. No clearing pass is needed.
//  - grace_ms lies at byte address 0, tick_ms at 4. Write them only while idle.
`default_nettype none

module multi_channel_liveness_watchdog import mclw_pkg::*; #(
   parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   mclw_req_if.sink              req_chan,
   mclw_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [31:0]       grace_ff;
   logic [TICK_W-1:0] tick_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff <= GRACE_RESET;
         tick_ff  <= TICK_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[CSR_SEL_BIT] == CSR_TICK) begin
            tick_ff <= pwdata[TICK_W-1:0];
         end else begin
            grace_ff <= pwdata;
         end
      end
   end

   assign prdata = (paddr[CSR_SEL_BIT] == CSR_TICK) ? 32'(tick_ff) : grace_ff;

   // ---------------------------------------------------------------------------------
   // Slot memories: id and period in one, last tick in the other
   // ---------------------------------------------------------------------------------
   logic [39:0] meta_mem [SLOTS];
   logic [31:0] tick_mem [SLOTS];
   logic [39:0] meta_rd_ff;
   logic [31:0] tick_rd_ff;

   // Per-slot flags live in flip-flops so that reset clears them at once.
   logic [SLOTS-1:0] used_ff;
   logic [SLOTS-1:0] seeded_ff;
   logic [SLOTS-1:0] armed_ff;
   logic [SLOTS-1:0] latched_ff;

   state_type        state_ff;
   req_type          req_ff;
   logic             bad_ff;
   logic [IDX_W-1:0] idx_ff;

   // Stage 1: memory data valid for slot idx1_ff.
   logic             v1_ff;
   logic [IDX_W-1:0] idx1_ff;

   // Stage 2: elapsed time and raw limit of a seeded slot.
   logic             v2_ff;
   logic [IDX_W-1:0] idx2_ff;
   logic [7:0]       task2_ff;
   logic [31:0]      period2_ff;
   logic [31:0]      el2_ff;
   logic [31:0]      lim3_ff;
   logic             armed2_ff;
   logic             latched2_ff;

   // Sweep results.
   logic             hit_found_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic             found_ff;
   logic [IDX_W-1:0] found_idx_ff;
   logic [7:0]       found_task_ff;
   logic [31:0]      found_el_ff;
   logic [31:0]      found_lim_ff;
   logic [31:0]      found_per_ff;

   logic [31:0] deferrals_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   // ---------------------------------------------------------------------------------
   // Stage 1 logic
   // ---------------------------------------------------------------------------------
   logic [7:0]  rd_task;
   logic [31:0] rd_period;
   logic        s1_used;
   logic        s1_seeded;
   logic        is_scan;
   logic        id_match;
   logic        seed_now;
   logic        check_now;
   logic [31:0] tick_diff;
   logic [41:0] el_prod;
   logic [31:0] lim3;

   assign rd_task   = meta_rd_ff[39:32];
   assign rd_period = meta_rd_ff[31:0];
   assign s1_used   = used_ff[idx1_ff];
   assign s1_seeded = seeded_ff[idx1_ff];
   assign is_scan   = (req_ff.op == OP_SCAN);

   assign id_match  = v1_ff && !is_scan && s1_used && (rd_task == req_ff.task_id);
   // Seed an unseeded slot; it is not checked on this scan.
   assign seed_now  = v1_ff && is_scan && s1_used && !s1_seeded;
   assign check_now = v1_ff && is_scan && s1_used && s1_seeded;

   // Elapsed ms wraps to 32 bits, like the tick difference.
   assign tick_diff = req_ff.now_tick - tick_rd_ff;
   assign el_prod   = {10'd0, tick_diff} * {32'd0, tick_ff};
   assign lim3      = (rd_period > PERIOD_SAT) ? LIMIT_MAX
                                               : rd_period + {rd_period[30:0], 1'b0};

   // ---------------------------------------------------------------------------------
   // Stage 2 logic: grace raise for unarmed slots, then the deadline compare
   // ---------------------------------------------------------------------------------
   logic [31:0] lim_adj;
   logic        stall_now;

   assign lim_adj   = (!armed2_ff && (lim3_ff < grace_ff)) ? grace_ff : lim3_ff;
   assign stall_now = v2_ff && (el2_ff > lim_adj) && !latched2_ff && !found_ff;

   // ---------------------------------------------------------------------------------
   // Finish step: decide the response and the table update
   // ---------------------------------------------------------------------------------
   logic             out_free;
   logic             fin;
   logic             fin_reg;
   logic             fin_alive;
   logic [IDX_W-1:0] fin_idx;
   logic             esc;
   logic [31:0]      deferrals_in;
   rsp_type          rsp_in;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign fin       = (state_ff == ST_FINISH) && out_free;
   assign fin_reg   = fin && !bad_ff && (req_ff.op == OP_REGISTER)
                      && (hit_found_ff || free_found_ff);
   assign fin_alive = fin && !bad_ff && (req_ff.op == OP_ALIVE) && hit_found_ff;
   assign fin_idx   = hit_found_ff ? hit_idx_ff : free_idx_ff;

   // Escalate unless the flagged task holds the lock; otherwise defer and count.
   assign esc = (found_task_ff != NULL_ID)
                && ((req_ff.holder_id == NULL_ID) || (req_ff.holder_id != found_task_ff));

   always_comb begin
      rsp_in       = '0;
      deferrals_in = deferrals_ff;
      priority if (bad_ff) begin
         rsp_in.status = STATUS_BAD_ARG;
      end else if (req_ff.op == OP_REGISTER) begin
         rsp_in.status = (hit_found_ff || free_found_ff) ? STATUS_OK : STATUS_FULL;
      end else if (is_scan && found_ff) begin
         rsp_in.escalate      = esc;
         rsp_in.deferred      = !esc;
         rsp_in.slot_index    = 4'(found_idx_ff);
         rsp_in.stalled_id    = found_task_ff;
         rsp_in.silence_span  = found_el_ff;
         rsp_in.deadline_span = found_lim_ff;
         rsp_in.stall_period  = found_per_ff;
         if (!esc) begin
            deferrals_in = deferrals_ff + 32'd1;
         end
      end else begin
         rsp_in.status = STATUS_OK;
      end
      rsp_in.deferral_count = deferrals_in;
   end

   // ---------------------------------------------------------------------------------
   // Memory ports: one read per cycle at the sweep index, one write per memory
   // ---------------------------------------------------------------------------------
   logic             tick_we;
   logic [IDX_W-1:0] tick_waddr;
   logic [31:0]      tick_wdata;

   always_comb begin
      tick_we    = 1'b0;
      tick_waddr = idx1_ff;
      tick_wdata = req_ff.now_tick;
      priority if (seed_now) begin
         tick_we = 1'b1;
      end else if (fin_reg) begin
         tick_we    = 1'b1;
         tick_waddr = fin_idx;
         tick_wdata = req_ff.kernel_running ? req_ff.now_tick : 32'd0;
      end else if (fin_alive) begin
         tick_we    = 1'b1;
         tick_waddr = hit_idx_ff;
      end else begin
         tick_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_reg) begin
         meta_mem[fin_idx] <= {req_ff.task_id, req_ff.task_period};
      end
      meta_rd_ff <= meta_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (tick_we) begin
         tick_mem[tick_waddr] <= tick_wdata;
      end
      tick_rd_ff <= tick_mem[idx_ff];
   end

   // ---------------------------------------------------------------------------------
   // Controller: state, sweep pipeline, flags and the response register
   // ---------------------------------------------------------------------------------
   logic req_fire;
   logic bad_in;
   logic req_ready_w;

   assign req_ready_w = (state_ff == ST_IDLE);
   assign req_fire    = req_chan.valid && req_ready_w;

   // Refuse null ids, zero periods and the unknown op without a sweep.
   assign bad_in = ((req_chan.payload.op == OP_REGISTER)
                    && ((req_chan.payload.task_id == NULL_ID)
                        || (req_chan.payload.task_period == 32'd0)))
                   || ((req_chan.payload.op == OP_ALIVE)
                       && (req_chan.payload.task_id == NULL_ID))
                   || ((req_chan.payload.op != OP_REGISTER)
                       && (req_chan.payload.op != OP_ALIVE)
                       && (req_chan.payload.op != OP_SCAN));

   assign req_chan.ready = req_ready_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         used_ff       <= '0;
         seeded_ff     <= '0;
         armed_ff      <= '0;
         latched_ff    <= '0;
         deferrals_ff  <= 32'd0;
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         found_ff      <= 1'b0;
         idx_ff        <= '0;
      end else begin
         // Advance the sweep pipeline.
         v1_ff       <= (state_ff == ST_SWEEP);
         idx1_ff     <= idx_ff;
         v2_ff       <= check_now;
         idx2_ff     <= idx1_ff;
         task2_ff    <= rd_task;
         period2_ff  <= rd_period;
         el2_ff      <= el_prod[31:0];
         lim3_ff     <= lim3;
         armed2_ff   <= armed_ff[idx1_ff];
         latched2_ff <= latched_ff[idx1_ff];

         // Record the first slot that holds the id and the first free slot.
         if (id_match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= idx1_ff;
         end
         if (v1_ff && !s1_used && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx1_ff;
         end
         if (seed_now) begin
            seeded_ff[idx1_ff] <= 1'b1;
         end

         // Capture the first stall of the scan.
         if (stall_now) begin
            found_ff      <= 1'b1;
            found_idx_ff  <= idx2_ff;
            found_task_ff <= task2_ff;
            found_el_ff   <= el2_ff;
            found_lim_ff  <= lim_adj;
            found_per_ff  <= period2_ff;
         end

         // Drop the response once taken, unless a new one replaces it in the same cycle.
         if (rsp_valid_ff && rsp_chan.ready && !fin) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  req_ff        <= req_chan.payload;
                  bad_ff        <= bad_in;
                  idx_ff        <= '0;
                  hit_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  found_ff      <= 1'b0;
                  state_ff      <= bad_in ? ST_FINISH : ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            ST_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_ff       <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  deferrals_ff <= deferrals_in;
                  state_ff     <= ST_IDLE;
                  if (fin_reg) begin
                     used_ff[fin_idx]    <= 1'b1;
                     seeded_ff[fin_idx]  <= req_ff.kernel_running;
                     armed_ff[fin_idx]   <= 1'b0;
                     latched_ff[fin_idx] <= 1'b0;
                  end
                  if (fin_alive) begin
                     seeded_ff[hit_idx_ff]  <= 1'b1;
                     armed_ff[hit_idx_ff]   <= 1'b1;
                     latched_ff[hit_idx_ff] <= 1'b0;
                  end
                  // Latch an escalated slot; a deferred one stays open for a retry.
                  if (!bad_ff && is_scan && found_ff) begin
                     latched_ff[found_idx_ff] <= esc;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire

// File: src/mclw_checker.sv
// Port-level assertions for the liveness watchdog and the bind that attaches them
// to the top level. Depends on mclw_pkg and multi_channel_liveness_watchdog.
`default_nettype none

module mclw_checker import mclw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // Hold a stalled response and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // No response comes out of reset.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // One request at a time: the block is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous request still in work");

   // A new response is only produced by the busy controller.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a request in work");

endmodule

bind multi_channel_liveness_watchdog mclw_checker u_mclw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire

// File: dv/tb.sv
// Testbench for multi_channel_liveness_watchdog: directed and random register, alive and scan
// requests, checked field by field against an in-bench prediction of the slot table.
// Depends on mclw_pkg, mclw_req_if, mclw_rsp_if and the watchdog top level.

module tb;
   import mclw_pkg::*;

   localparam int unsigned SLOTS       = SLOTS_DEFAULT;
   // Settle time that wait_for_quiet waits after the last answer has arrived.
   localparam int unsigned SETTLE_CYC  = 2 * (SLOTS + 4);
   localparam logic [1:0]  OP_UNDEFINED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_GRACE =
      CSR_ADDR_W'(CSR_GRACE) << CSR_SEL_BIT;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TICK  =
      CSR_ADDR_W'(CSR_TICK) << CSR_SEL_BIT;
   localparam logic [7:0]  ID_POOL_TOP = 8'd20;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   mclw_req_if req_chan ();
   mclw_rsp_if rsp_chan ();

   multi_channel_liveness_watchdog u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Mirror of the slot table and registers, advanced once per request.
   logic [7:0]  slot_id_m     [SLOTS];
   logic [31:0] slot_period_m [SLOTS];
   logic [31:0] slot_last_m   [SLOTS];
   bit          slot_used_m   [SLOTS];
   bit          slot_seeded_m [SLOTS];
   bit          slot_armed_m  [SLOTS];
   bit          slot_latched_m[SLOTS];
   logic [31:0] deferral_total;
   logic [31:0] grace_m;
   logic [TICK_W-1:0] tick_m;

   rsp_type     expected_verdicts[$];
   int          mismatch_count;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   logic [31:0] wall_tick;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #12000000;
      $display("Regression FAIL");
      $finish;
   end

   // Deadline for a period: three periods, saturating at the top of the range.
   function automatic logic [31:0] deadline_of(logic [31:0] period);
      return (period > PERIOD_SAT) ? LIMIT_MAX : 32'(period * 32'd3);
   endfunction

   // Apply one request to the mirror and return the verdict it must produce.
   function automatic rsp_type predict_watchdog(req_type rq);
      rsp_type     v;
      int          hit;
      int          found;
      logic [31:0] silence;
      logic [31:0] deadline;
      v        = '0;
      v.status = STATUS_OK;
      hit      = -1;
      found    = -1;
      case (rq.op)
         OP_REGISTER: begin
            if (rq.task_id == NULL_ID || rq.task_period == 32'd0) begin
               v.status = STATUS_BAD_ARG;
            end else begin
               // Refresh a slot holding the id, else take the first free one.
               for (int i = 0; i < SLOTS; i++)
                  if (hit < 0 && slot_used_m[i] && slot_id_m[i] == rq.task_id) hit = i;
               for (int i = 0; i < SLOTS; i++)
                  if (hit < 0 && !slot_used_m[i]) hit = i;
               if (hit < 0) begin
                  v.status = STATUS_FULL;
               end else begin
                  slot_id_m[hit]      = rq.task_id;
                  slot_period_m[hit]  = rq.task_period;
                  slot_last_m[hit]    = rq.kernel_running ? rq.now_tick : 32'd0;
                  slot_seeded_m[hit]  = rq.kernel_running;
                  slot_armed_m[hit]   = 1'b0;
                  slot_latched_m[hit] = 1'b0;
                  slot_used_m[hit]    = 1'b1;
               end
            end
         end
         OP_ALIVE: begin
            if (rq.task_id == NULL_ID) begin
               v.status = STATUS_BAD_ARG;
            end else begin
               for (int i = 0; i < SLOTS; i++)
                  if (hit < 0 && slot_used_m[i] && slot_id_m[i] == rq.task_id) hit = i;
               if (hit >= 0) begin
                  slot_last_m[hit]    = rq.now_tick;
                  slot_seeded_m[hit]  = 1'b1;
                  slot_armed_m[hit]   = 1'b1;
                  slot_latched_m[hit] = 1'b0;
               end
            end
         end
         OP_SCAN: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used_m[i]) begin
                  if (!slot_seeded_m[i]) begin
                     slot_last_m[i]   = rq.now_tick;
                     slot_seeded_m[i] = 1'b1;
                  end else begin
                     silence  = 32'((rq.now_tick - slot_last_m[i]) * 32'(tick_m));
                     deadline = deadline_of(slot_period_m[i]);
                     if (!slot_armed_m[i] && deadline < grace_m) deadline = grace_m;
                     if (silence > deadline && !slot_latched_m[i] && found < 0) begin
                        slot_latched_m[i] = 1'b1;
                        found             = i;
                        v.silence_span    = silence;
                        v.deadline_span   = deadline;
                        v.stall_period    = slot_period_m[i];
                     end
                  end
               end
            end
            if (found >= 0) begin
               v.slot_index = 4'(found);
               v.stalled_id = slot_id_m[found];
               if (v.stalled_id != NULL_ID &&
                   (rq.holder_id == NULL_ID || rq.holder_id != v.stalled_id)) begin
                  v.escalate = 1'b1;
               end else begin
                  // Lock holder stalled: count it and let the next scan retry.
                  v.deferred            = 1'b1;
                  deferral_total        = deferral_total + 32'd1;
                  slot_latched_m[found] = 1'b0;
               end
            end
         end
         default: v.status = STATUS_BAD_ARG;
      endcase
      v.deferral_count = deferral_total;
      return v;
   endfunction

   function automatic req_type make_event(logic [1:0] op, logic [7:0] id,
                                          logic [31:0] period, logic [31:0] now,
                                          logic run, logic [7:0] holder);
      req_type rq;
      rq.op             = op;
      rq.task_id        = id;
      rq.task_period    = period;
      rq.now_tick       = now;
      rq.kernel_running = run;
      rq.holder_id      = holder;
      return rq;
   endfunction

   // Mostly a small pool of ids so that refreshes and a full table happen.
   function automatic logic [7:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 5)  return NULL_ID;
      if (r < 85) return 8'($urandom_range(ID_POOL_TOP, 1));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_used_id();
      logic [7:0] ids[$];
      for (int i = 0; i < SLOTS; i++)
         if (slot_used_m[i]) ids.push_back(slot_id_m[i]);
      if (ids.size() == 0) return pick_id();
      return ids[$urandom_range(ids.size() - 1)];
   endfunction

   function automatic logic [31:0] pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 32'($urandom_range(40, 1));
      if (r < 72) return 32'($urandom_range(5000, 1));
      if (r < 82) return 32'($urandom);
      if (r < 87) return 32'd0;
      if (r < 93) return PERIOD_SAT + 32'($urandom_range(1));
      if (r < 97) return LIMIT_MAX;
      return 32'($urandom_range(2, 1));
   endfunction

   function automatic logic [7:0] pick_holder();
      int r;
      r = $urandom_range(99);
      if (r < 35) return pick_used_id();
      if (r < 70) return NULL_ID;
      if (r < 85) return 8'($urandom_range(ID_POOL_TOP, 1));
      return 8'($urandom_range(255));
   endfunction

   // Build a random request. Advance the wall clock, mostly in small steps, now and then
   // jumping or stepping back so that the elapsed difference wraps.
   function automatic req_type make_random_event();
      int         r;
      logic [1:0] op;
      r = $urandom_range(99);
      if (r < 85)      wall_tick = wall_tick + 32'($urandom_range(25));
      else if (r < 95) wall_tick = wall_tick + 32'($urandom_range(2000));
      else if (r < 98) wall_tick = 32'($urandom);
      else             wall_tick = wall_tick - 32'($urandom_range(50));
      r = $urandom_range(99);
      if (r < 25)      op = OP_REGISTER;
      else if (r < 60) op = OP_ALIVE;
      else if (r < 95) op = OP_SCAN;
      else             op = OP_UNDEFINED;
      return make_event(op,
                        (op == OP_ALIVE && $urandom_range(99) < 70) ? pick_used_id()
                                                                    : pick_id(),
                        pick_period(), wall_tick,
                        logic'($urandom_range(99) < 85), pick_holder());
   endfunction

   // Predict, then hold the request on the channel until the block takes it.
   task automatic issue_event(input req_type rq);
      expected_verdicts.push_back(predict_watchdog(rq));
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= rq;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid, let every outstanding answer arrive, then let the block settle.
   task automatic wait_for_quiet();
      req_chan.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_GRACE) grace_m = value;
      else                    tick_m  = value[TICK_W-1:0];
   endtask

   task automatic program_registers(input logic [31:0] grace, input logic [31:0] tick);
      wait_for_quiet();
      write_register(ADDR_GRACE, grace);
      write_register(ADDR_TICK, tick);
   endtask

   task automatic run_random_events(input int count);
      for (int n = 0; n < count; n++) issue_event(make_random_event());
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Refused and ignored requests under reset settings.
   task automatic test_refused_events();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      issue_event(make_event(OP_UNDEFINED, 8'hFF, LIMIT_MAX, LIMIT_MAX, 1'b1, 8'hFF));
      issue_event(make_event(OP_REGISTER, NULL_ID, 32'd5, 32'd0, 1'b1, NULL_ID));
      issue_event(make_event(OP_REGISTER, 8'd5, 32'd0, 32'd0, 1'b1, NULL_ID));
      issue_event(make_event(OP_ALIVE, NULL_ID, 32'd0, 32'd7, 1'b1, NULL_ID));
      issue_event(make_event(OP_ALIVE, 8'd77, 32'd0, 32'd7, 1'b1, NULL_ID));
   endtask

   // Stall detection: escalation, deferral and its retry, several stalls in
   // one scan, saturated limits, unseeded slots and the grace window.
   task automatic test_escalation_and_deferral();
      issue_event(make_event(OP_REGISTER, 8'hFF, LIMIT_MAX, LIMIT_MAX, 1'b1, NULL_ID));
      issue_event(make_event(OP_REGISTER, 8'd1, PERIOD_SAT + 32'd1, 32'd1234, 1'b0, NULL_ID));
      issue_event(make_event(OP_REGISTER, 8'd3, 32'd10, 32'd100, 1'b1, NULL_ID));
      issue_event(make_event(OP_REGISTER, 8'd4, 32'd20, 32'd100, 1'b1, NULL_ID));
      issue_event(make_event(OP_ALIVE, 8'd3, 32'd0, 32'd100, 1'b1, NULL_ID));
      issue_event(make_event(OP_ALIVE, 8'd4, 32'd0, 32'd100, 1'b1, NULL_ID));
      issue_event(make_event(OP_SCAN, NULL_ID, 32'd0, 32'd131, 1'b1, 8'd3));
      issue_event(make_event(OP_SCAN, NULL_ID, 32'd0, 32'd161, 1'b1, NULL_ID));
      issue_event(make_event(OP_SCAN, NULL_ID, 32'd0, 32'd161, 1'b1, 8'd200));
      issue_event(make_event(OP_ALIVE, 8'd3, 32'd0, 32'd170, 1'b1, NULL_ID));
      issue_event(make_event(OP_REGISTER, 8'd3, 32'd1, 32'd170, 1'b0, NULL_ID));
      issue_event(make_event(OP_SCAN, NULL_ID, 32'd0, 32'd200, 1'b1, NULL_ID));
      issue_event(make_event(OP_SCAN, NULL_ID, 32'd0, 32'd60300, 1'b1, 8'd3));
      issue_event(make_event(OP_SCAN, NULL_ID, 32'd0, 32'd60300, 1'b1, 8'd3));
      wall_tick = 32'd60300;
   endtask

   // Tight grace: unarmed slots stall almost at once; no idling.
   task automatic test_tight_grace();
      program_registers(32'd50, 32'd1);
      run_random_events(400);
   endtask

   // Zero grace and a coarse tick with a slow sender; pause midway until drained.
   task automatic test_coarse_tick();
      program_registers(32'd0, 32'd1000);
      sender_idle_pct = 59;
      run_random_events(200);
      wait_for_quiet();
      run_random_events(200);
   endtask

   // Maximal grace and the widest tick code with a stalling receiver.
   task automatic test_max_grace();
      program_registers(LIMIT_MAX, 32'h3FF);
      sender_idle_pct    = 0;
      receiver_stall_pct = 59;
      run_random_events(400);
   endtask

   // Zero tick: nothing can stall; both sides idle.
   task automatic test_zero_tick();
      program_registers(32'd200, 32'd0);
      sender_idle_pct    = 34;
      receiver_stall_pct = 34;
      run_random_events(250);
   endtask

   task automatic test_mixed_settings();
      program_registers(GRACE_RESET, 32'd7);
      run_random_events(300);
      program_registers(32'd400, 32'd1);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random_events(200);
   endtask

   // Receiver: stall at random according to the current phase.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Compare every accepted answer with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected answer: expected none, actual %0h",
                     $time, rsp_chan.payload);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_chan.payload.status));
            check_field("escalate", 32'(want.escalate), 32'(rsp_chan.payload.escalate));
            check_field("deferred", 32'(want.deferred), 32'(rsp_chan.payload.deferred));
            check_field("slot_index", 32'(want.slot_index), 32'(rsp_chan.payload.slot_index));
            check_field("stalled_id", 32'(want.stalled_id), 32'(rsp_chan.payload.stalled_id));
            check_field("silence_span", want.silence_span, rsp_chan.payload.silence_span);
            check_field("deadline_span", want.deadline_span, rsp_chan.payload.deadline_span);
            check_field("stall_period", want.stall_period,
                        rsp_chan.payload.stall_period);
            check_field("deferral_count", want.deferral_count,
                        rsp_chan.payload.deferral_count);
         end
      end
   end

   initial begin
      mismatch_count     = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      wall_tick          = 32'd0;
      deferral_total     = 32'd0;
      grace_m            = GRACE_RESET;
      tick_m             = TICK_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         slot_id_m[i]      = '0;
         slot_period_m[i]  = '0;
         slot_last_m[i]    = '0;
         slot_used_m[i]    = 1'b0;
         slot_seeded_m[i]  = 1'b0;
         slot_armed_m[i]   = 1'b0;
         slot_latched_m[i] = 1'b0;
      end
      // Hold every input at a known value through reset.
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_refused_events();
      test_escalation_and_deferral();
      test_tight_grace();
      test_coarse_tick();
      test_max_grace();
      test_zero_tick();
      test_mixed_settings();
      wait_for_quiet();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/mclw_pkg.sv
src/mclw_req_if.sv
src/mclw_rsp_if.sv
src/multi_channel_liveness_watchdog.sv
src/mclw_checker.sv
dv/tb.sv
